@@ rtl/swlap_pkg.sv @@
// Package with the shared types and constants of the stopwatch block.
package swlap_pkg;

    // Number of lap entries and the width of the fill count.
    localparam int LAP_DEPTH = 6;
    localparam int LAP_CNT_W = $clog2(LAP_DEPTH + 1);

    // Elapsed time limits; the count wraps to zero after the last value.
    localparam logic [28:0] MS_MAX      = 29'd359999999;
    localparam logic [28:0] ALARM_RESET = 29'd3000;

    // Last value of each display digit group.
    localparam logic [3:0] MS_DIGIT_MAX = 4'd9;
    localparam logic [6:0] CS_MAX       = 7'd99;
    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [5:0] MIN_MAX      = 6'd59;
    localparam logic [6:0] HR_MAX       = 7'd99;

    // Operation codes carried with each input word.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LAP    = 2'd3
    } sw_op_t;

    // Time and run state after an operation has taken effect.
    typedef struct packed {
        logic       alarm_hit;
        logic       is_running;
        logic [6:0] centiseconds;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [6:0] hours;
    } sw_time_view_t;

    // Lap store view for the requested entry.
    typedef struct packed {
        logic        lap_valid;
        logic [28:0] lap_value_ms;
        logic [2:0]  laps_stored;
    } sw_lap_view_t;

    // One complete result word.
    typedef struct packed {
        sw_lap_view_t  lap;
        sw_time_view_t tim;
    } sw_result_t;

endpackage

@@ rtl/stopwatch_with_laps_and_alarm.sv @@
// Top level of the millisecond stopwatch with lap store and alarm flag.
//
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | one operation word, lap entry to read
//  m_      | out       | m_tvalid/m_tready  | time digits, flags, lap count and entry
//  cfg_    | in        | cfg_valid/cfg_ready| alarm time in milliseconds
//
// Each input word yields one registered result word (result register or skid stage);
// one word is taken in every cycle while the skid stage is empty, by the single pass.
// Reset (aresetn low, synchronous) stops the watch, clears the time and the lap
// count and loads the alarm time of 3000 ms; lap entries hold no reset value.
// A stalled output is held in the result register, and one more word is taken
// into the skid stage before s_tready falls. Configuration is always ready.
module stopwatch_with_laps_and_alarm (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] lap_index, [7:3] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [6:0] hours, [12:7] minutes, [18:13] seconds,
                                   // [25:19] centiseconds, [26] alarm_hit,
                                   // [27] is_running, [30:28] laps_stored,
                                   // [59:31] lap_value_ms, [63:60] zero
    output logic [0:0]  m_tuser,   // [0] lap_valid
    // Alarm time register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [28:0] cfg_data
);

    logic                    accept;
    logic                    cfg_we;
    logic [28:0]             elapsed_next;
    swlap_pkg::sw_time_view_t time_view;
    swlap_pkg::sw_lap_view_t  lap_view;
    swlap_pkg::sw_result_t    result;
    swlap_pkg::sw_result_t    out_result;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    // Time counters and alarm.
    swlap_time_core u_time (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (accept),
        .op           (s_tuser),
        .cfg_we       (cfg_we),
        .cfg_alarm    (cfg_data),
        .elapsed_next (elapsed_next),
        .view         (time_view)
    );

    // Lap store; a lap mark leaves the time unchanged, so the updated time is pushed.
    swlap_lap_store u_laps (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .op        (s_tuser),
        .elapsed   (elapsed_next),
        .lap_index (s_tdata[2:0]),
        .view      (lap_view)
    );

    assign result.tim = time_view;
    assign result.lap = lap_view;

    // Output register and skid stage.
    swlap_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result word.
    assign m_tdata = {4'b0000,
                      out_result.lap.lap_value_ms,
                      out_result.lap.laps_stored,
                      out_result.tim.is_running,
                      out_result.tim.alarm_hit,
                      out_result.tim.centiseconds,
                      out_result.tim.seconds,
                      out_result.tim.minutes,
                      out_result.tim.hours};
    assign m_tuser = out_result.lap.lap_valid;

endmodule

@@ rtl/swlap_time_core.sv @@
// Elapsed time counters, run state and alarm comparator of the stopwatch.
module swlap_time_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [1:0]             op,
    input  logic                   cfg_we,
    input  logic [28:0]            cfg_alarm,
    output logic [28:0]            elapsed_next,
    output swlap_pkg::sw_time_view_t view
);

    logic        running_reg, running_next;
    logic [28:0] elapsed_reg;
    logic [28:0] alarm_reg;
    logic [3:0]  ms_reg, ms_next;
    logic [6:0]  cs_reg, cs_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [6:0]  hr_reg, hr_next;
    swlap_pkg::sw_op_t op_code;

    assign op_code = swlap_pkg::sw_op_t'(op);

    // Next state: a binary count for compare and laps, mixed-radix digits for display.
    always_comb begin
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        ms_next      = ms_reg;
        cs_next      = cs_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hr_next      = hr_reg;
        case (op_code)
            swlap_pkg::OP_TICK: begin
                if (running_reg) begin
                    if (elapsed_reg == swlap_pkg::MS_MAX) begin
                        elapsed_next = '0;
                    end else begin
                        elapsed_next = 29'(elapsed_reg + 29'd1);
                    end
                    if (ms_reg == swlap_pkg::MS_DIGIT_MAX) begin
                        ms_next = '0;
                        if (cs_reg == swlap_pkg::CS_MAX) begin
                            cs_next = '0;
                            if (sec_reg == swlap_pkg::SEC_MAX) begin
                                sec_next = '0;
                                if (min_reg == swlap_pkg::MIN_MAX) begin
                                    min_next = '0;
                                    if (hr_reg == swlap_pkg::HR_MAX) begin
                                        hr_next = '0;
                                    end else begin
                                        hr_next = 7'(hr_reg + 7'd1);
                                    end
                                end else begin
                                    min_next = 6'(min_reg + 6'd1);
                                end
                            end else begin
                                sec_next = 6'(sec_reg + 6'd1);
                            end
                        end else begin
                            cs_next = 7'(cs_reg + 7'd1);
                        end
                    end else begin
                        ms_next = 4'(ms_reg + 4'd1);
                    end
                end
            end
            swlap_pkg::OP_TOGGLE: begin
                running_next = !running_reg;
            end
            swlap_pkg::OP_CLEAR: begin
                elapsed_next = '0;
                ms_next      = '0;
                cs_next      = '0;
                sec_next     = '0;
                min_next     = '0;
                hr_next      = '0;
            end
            default: begin
            end
        endcase
    end

    // State registers advance only when a word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            ms_reg      <= '0;
            cs_reg      <= '0;
            sec_reg     <= '0;
            min_reg     <= '0;
            hr_reg      <= '0;
        end else if (en) begin
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            ms_reg      <= ms_next;
            cs_reg      <= cs_next;
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hr_reg      <= hr_next;
        end
    end

    // Alarm time register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg <= swlap_pkg::ALARM_RESET;
        end else if (cfg_we) begin
            alarm_reg <= cfg_alarm;
        end
    end

    // Result view of the state after the operation.
    always_comb begin
        view.alarm_hit    = (elapsed_next == alarm_reg);
        view.is_running   = running_next;
        view.centiseconds = cs_next;
        view.seconds      = sec_next;
        view.minutes      = min_next;
        view.hours        = hr_next;
    end

endmodule

@@ rtl/swlap_lap_store.sv @@
// Lap store: a shift line of recorded times with a fill count and a read select.
module swlap_lap_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [1:0]             op,
    input  logic [28:0]            elapsed,
    input  logic [2:0]             lap_index,
    output swlap_pkg::sw_lap_view_t view
);

    logic [28:0] store_reg  [swlap_pkg::LAP_DEPTH];
    logic [28:0] store_next [swlap_pkg::LAP_DEPTH];
    logic [swlap_pkg::LAP_CNT_W-1:0] count_reg, count_next;
    logic        push;
    logic        hit;
    logic [28:0] sel_value;

    // A lap mark is taken only while the store has room.
    assign push = en && (swlap_pkg::sw_op_t'(op) == swlap_pkg::OP_LAP) &&
                  (count_reg < swlap_pkg::LAP_CNT_W'(swlap_pkg::LAP_DEPTH));

    // The newest time enters at the front and older entries move back one place.
    always_comb begin
        store_next[0] = push ? elapsed : store_reg[0];
        for (int i = 1; i < swlap_pkg::LAP_DEPTH; i++) begin
            store_next[i] = push ? store_reg[i-1] : store_reg[i];
        end
        count_next = push ? swlap_pkg::LAP_CNT_W'(count_reg + 1'b1) : count_reg;
    end

    // Entries hold payload only; the fill count tells which are meaningful.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < swlap_pkg::LAP_DEPTH; i++) begin
            store_reg[i] <= store_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Select the requested entry from the updated store.
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < swlap_pkg::LAP_DEPTH; i++) begin
            if (32'(lap_index) == i) begin
                sel_value = store_next[i];
            end
        end
        hit = (32'(lap_index) < 32'(count_next));
        view.lap_valid    = hit;
        view.lap_value_ms = hit ? sel_value : '0;
        view.laps_stored  = 3'(count_next);
    end

endmodule

@@ rtl/swlap_out_buf.sv @@
// Result register with a skid stage so input and output stalls stay apart.
module swlap_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  swlap_pkg::sw_result_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output swlap_pkg::sw_result_t out_data
);

    logic                  main_valid_reg, main_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    swlap_pkg::sw_result_t main_reg, main_next;
    swlap_pkg::sw_result_t skid_reg, skid_next;
    logic                  in_acc;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;

    // The main register refills from the skid stage first, then from the input.
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = in_data;
                main_valid_next = in_acc;
            end
        end else if (in_acc) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
